// File: hdl/sle_pkg.sv
`default_nettype none

package sle_pkg;

	localparam logic [3:0] OP_PUSH_FRONT   = 4'd0;
	localparam logic [3:0] OP_PUSH_BACK    = 4'd1;
	localparam logic [3:0] OP_INSERT       = 4'd2;
	localparam logic [3:0] OP_POP_FRONT    = 4'd3;
	localparam logic [3:0] OP_POP_BACK     = 4'd4;
	localparam logic [3:0] OP_ERASE        = 4'd5;
	localparam logic [3:0] OP_FIND         = 4'd6;
	localparam logic [3:0] OP_REMOVE_FIRST = 4'd7;
	localparam logic [3:0] OP_REMOVE_ALL   = 4'd8;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_BAD_INDEX = 3'd1;
	localparam logic [2:0] ST_FULL      = 3'd2;
	localparam logic [2:0] ST_EMPTY     = 3'd3;
	localparam logic [2:0] ST_NOT_FOUND = 3'd4;

	localparam int DATA_W = 32;

	typedef struct packed {
		logic [2:0] status;
		logic [3:0] found_position;
		logic [4:0] entry_count;
	} res_t;

endpackage

`default_nettype wire

// File: hdl/sequential_list_engine.sv
// Pop back, bad index, full, empty and ignored opcodes go from the check state straight to
// done; scans, remove first and remove all walk the list entries before the result. Shifts,
// scans and compaction move one entry a cycle through the single list memory port pair.
// One transaction is in flight at a time; the next is accepted once the held result has
// been passed to the output register, which waits while out_stall holds a result there.
// Reset clears the count (empty list) and all control state; the list memory is not cleared.
`default_nettype none

module sequential_list_engine #(
	parameter int CAPACITY = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [3:0]         opcode,
	input  wire logic [4:0]         position,
	input  wire logic signed [31:0] value,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [2:0]              status,
	output logic [3:0]              found_position,
	output logic [4:0]              entry_count
);

	logic          seq_idle;
	logic          seq_done;
	logic          take;
	sle_pkg::res_t res;
	sle_pkg::res_t res_q;
	logic          out_valid_q;

	assign take = seq_done && (!out_valid_q || !out_stall);

	sle_seq #(
		.CAPACITY(CAPACITY)
	) u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (in_valid && seq_idle),
		.opcode  (opcode),
		.position(position),
		.value   (value),
		.idle    (seq_idle),
		.done    (seq_done),
		.take    (take),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			res_q <= res;
		end
	end

	assign in_stall       = !seq_idle;
	assign out_valid      = out_valid_q;
	assign status         = res_q.status;
	assign found_position = res_q.found_position;
	assign entry_count    = res_q.entry_count;

endmodule

`default_nettype wire

// File: hdl/sle_mem.sv
`default_nettype none

module sle_mem #(
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  wire logic                      clk,
	input  wire logic                      we,
	input  wire logic [AW-1:0]             waddr,
	input  wire logic [sle_pkg::DATA_W-1:0] wdata,
	input  wire logic [AW-1:0]             raddr,
	output logic      [sle_pkg::DATA_W-1:0] rdata
);

	logic [sle_pkg::DATA_W-1:0] mem [DEPTH];
	logic [sle_pkg::DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// File: hdl/sle_seq.sv
`default_nettype none

module sle_seq #(
	parameter int CAPACITY = 16
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire logic [3:0]          opcode,
	input  wire logic [4:0]          position,
	input  wire logic signed [31:0]  value,
	output logic                     idle,
	output logic                     done,
	input  wire logic                take,
	output sle_pkg::res_t            res
);

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int PW = (CW > 5) ? CW : 5;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_SHIFT_UP,
		S_PUT,
		S_SHIFT_DN,
		S_SCAN,
		S_COMPACT,
		S_DONE
	} state_t;

	state_t                     state_q;
	logic [3:0]                 op_q;
	logic [PW-1:0]              pos_q;
	logic [sle_pkg::DATA_W-1:0] value_q;
	logic [CW-1:0]              count_q;
	logic [PW-1:0]              ptr_q;
	logic [PW-1:0]              at_q;
	logic [CW-1:0]              j_q;
	logic [AW-1:0]              wdst_q;
	logic [AW-1:0]              idx_q;
	logic [AW-1:0]              where_q;
	logic                       rv_q;
	logic [2:0]                 status_q;

	logic [PW-1:0]              count_w;
	logic [PW-1:0]              ins_at;
	logic                       hit;
	logic                       mem_we;
	logic [AW-1:0]              mem_waddr;
	logic [sle_pkg::DATA_W-1:0] mem_wdata;
	logic [AW-1:0]              mem_raddr;
	logic [sle_pkg::DATA_W-1:0] mem_rdata;

	sle_mem #(
		.DEPTH(CAPACITY),
		.AW   (AW)
	) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	assign count_w = PW'(count_q);
	assign hit     = rv_q && (mem_rdata == value_q);

	always_comb begin
		unique case (op_q)
			sle_pkg::OP_PUSH_FRONT: ins_at = '0;
			sle_pkg::OP_PUSH_BACK:  ins_at = count_w;
			default:                ins_at = pos_q;
		endcase
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = wdst_q;
		mem_wdata = mem_rdata;
		mem_raddr = ptr_q[AW-1:0];
		unique case (state_q)
			S_SHIFT_UP: begin
				mem_we    = rv_q;
				mem_raddr = AW'(ptr_q - PW'(1));
			end
			S_SHIFT_DN: begin
				mem_we = rv_q;
			end
			S_PUT: begin
				mem_we    = 1'b1;
				mem_waddr = at_q[AW-1:0];
				mem_wdata = value_q;
			end
			S_COMPACT: begin
				mem_we    = rv_q && (mem_rdata != value_q);
				mem_waddr = j_q[AW-1:0];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			op_q     <= '0;
			pos_q    <= '0;
			value_q  <= '0;
			count_q  <= '0;
			ptr_q    <= '0;
			at_q     <= '0;
			j_q      <= '0;
			wdst_q   <= '0;
			idx_q    <= '0;
			where_q  <= '0;
			rv_q     <= 1'b0;
			status_q <= sle_pkg::ST_OK;
		end else begin
			rv_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						op_q     <= opcode;
						pos_q    <= PW'(position);
						value_q  <= value;
						status_q <= sle_pkg::ST_OK;
						where_q  <= '0;
						state_q  <= S_CHECK;
					end
				end
				S_CHECK: begin
					unique case (op_q)
						sle_pkg::OP_PUSH_FRONT, sle_pkg::OP_PUSH_BACK,
						sle_pkg::OP_INSERT: begin
							if (ins_at > count_w) begin
								status_q <= sle_pkg::ST_BAD_INDEX;
								state_q  <= S_DONE;
							end else if (count_q >= CW'(CAPACITY)) begin
								status_q <= sle_pkg::ST_FULL;
								state_q  <= S_DONE;
							end else begin
								at_q    <= ins_at;
								ptr_q   <= count_w;
								state_q <= S_SHIFT_UP;
							end
						end
						sle_pkg::OP_POP_FRONT: begin
							if (count_q == '0) begin
								status_q <= sle_pkg::ST_EMPTY;
								state_q  <= S_DONE;
							end else begin
								ptr_q   <= PW'(1);
								state_q <= S_SHIFT_DN;
							end
						end
						sle_pkg::OP_POP_BACK: begin
							if (count_q == '0) begin
								status_q <= sle_pkg::ST_EMPTY;
							end else begin
								count_q <= count_q - CW'(1);
							end
							state_q <= S_DONE;
						end
						sle_pkg::OP_ERASE: begin
							if (pos_q >= count_w) begin
								status_q <= sle_pkg::ST_BAD_INDEX;
								state_q  <= S_DONE;
							end else begin
								ptr_q   <= pos_q + PW'(1);
								state_q <= S_SHIFT_DN;
							end
						end
						sle_pkg::OP_FIND, sle_pkg::OP_REMOVE_FIRST: begin
							ptr_q   <= '0;
							state_q <= S_SCAN;
						end
						sle_pkg::OP_REMOVE_ALL: begin
							ptr_q   <= '0;
							j_q     <= '0;
							state_q <= S_COMPACT;
						end
						default: begin
							state_q <= S_DONE;
						end
					endcase
				end
				S_SHIFT_UP: begin
					if (ptr_q > at_q) begin
						rv_q   <= 1'b1;
						wdst_q <= AW'(ptr_q);
						ptr_q  <= ptr_q - PW'(1);
					end else begin
						state_q <= S_PUT;
					end
				end
				S_PUT: begin
					count_q <= count_q + CW'(1);
					state_q <= S_DONE;
				end
				S_SHIFT_DN: begin
					if (ptr_q < count_w) begin
						rv_q   <= 1'b1;
						wdst_q <= AW'(ptr_q - PW'(1));
						ptr_q  <= ptr_q + PW'(1);
					end else begin
						count_q <= count_q - CW'(1);
						state_q <= S_DONE;
					end
				end
				S_SCAN: begin
					if (hit) begin
						where_q <= idx_q;
						if (op_q == sle_pkg::OP_REMOVE_FIRST) begin
							ptr_q   <= PW'(idx_q) + PW'(1);
							state_q <= S_SHIFT_DN;
						end else begin
							state_q <= S_DONE;
						end
					end else if (ptr_q < count_w) begin
						rv_q  <= 1'b1;
						idx_q <= AW'(ptr_q);
						ptr_q <= ptr_q + PW'(1);
					end else if (!rv_q) begin
						status_q <= sle_pkg::ST_NOT_FOUND;
						state_q  <= S_DONE;
					end
				end
				S_COMPACT: begin
					if (rv_q && (mem_rdata != value_q)) begin
						j_q <= j_q + CW'(1);
					end
					if (ptr_q < count_w) begin
						rv_q  <= 1'b1;
						ptr_q <= ptr_q + PW'(1);
					end else if (!rv_q) begin
						if (j_q == count_q) begin
							status_q <= sle_pkg::ST_NOT_FOUND;
						end
						count_q <= j_q;
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (take) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign idle               = (state_q == S_IDLE);
	assign done               = (state_q == S_DONE);
	assign res.status         = status_q;
	assign res.found_position = 4'(where_q);
	assign res.entry_count    = 5'(count_q);

endmodule

`default_nettype wire

// File: tb/testbench.sv
`default_nettype none

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LIST_DEPTH = 16;
	localparam int RANDOM_REQUESTS = 1000;
	localparam int MAX_WAIT = 17;
	localparam int REPORT_LIMIT = 10;
	localparam logic [3:0] OP_CODE_MAX = 4'd15;

	typedef enum int {IDLE_NONE, IDLE_FULL, IDLE_SPARSE} idle_mode_t;

	typedef struct packed {
		logic [3:0]    op;
		sle_pkg::res_t res;
	} pending_t;

	class list_scoreboard;
		int depth;
		logic [31:0] contents[$];
		pending_t awaiting[$];
		int failures;
		int checked;
		int peak;
		int status_hits[8];

		function new(int d);
			depth = d;
		endfunction

		function int outstanding();
			return awaiting.size();
		endfunction

		function void note_request(logic [3:0] op, logic [4:0] pos, logic [31:0] v);
			pending_t p;
			logic [31:0] kept[$];
			int at;
			int where;
			p.op = op;
			p.res.status = sle_pkg::ST_OK;
			p.res.found_position = '0;
			at = int'(pos);
			where = -1;
			case (op)
			sle_pkg::OP_PUSH_FRONT, sle_pkg::OP_PUSH_BACK, sle_pkg::OP_INSERT: begin
				if (op == sle_pkg::OP_PUSH_FRONT) at = 0;
				else if (op == sle_pkg::OP_PUSH_BACK) at = contents.size();
				if (at > contents.size()) p.res.status = sle_pkg::ST_BAD_INDEX;
				else if (contents.size() >= depth) p.res.status = sle_pkg::ST_FULL;
				else contents.insert(at, v);
			end
			sle_pkg::OP_POP_FRONT, sle_pkg::OP_POP_BACK: begin
				if (contents.size() == 0) p.res.status = sle_pkg::ST_EMPTY;
				else if (op == sle_pkg::OP_POP_FRONT) void'(contents.pop_front());
				else void'(contents.pop_back());
			end
			sle_pkg::OP_ERASE: begin
				if (at >= contents.size()) p.res.status = sle_pkg::ST_BAD_INDEX;
				else contents.delete(at);
			end
			sle_pkg::OP_FIND, sle_pkg::OP_REMOVE_FIRST: begin
				foreach (contents[i])
					if (where < 0 && contents[i] == v) where = i;
				if (where < 0) begin
					p.res.status = sle_pkg::ST_NOT_FOUND;
				end else begin
					p.res.found_position = 4'(where);
					if (op == sle_pkg::OP_REMOVE_FIRST) contents.delete(where);
				end
			end
			sle_pkg::OP_REMOVE_ALL: begin
				foreach (contents[i])
					if (contents[i] != v) kept.push_back(contents[i]);
				if (kept.size() == contents.size()) p.res.status = sle_pkg::ST_NOT_FOUND;
				contents = kept;
			end
			default: ;
			endcase
			p.res.entry_count = 5'(contents.size());
			if (contents.size() > peak) peak = contents.size();
			status_hits[p.res.status]++;
			awaiting.push_back(p);
		endfunction

		function void check_result(sle_pkg::res_t got);
			pending_t p;
			if (awaiting.size() == 0) begin
				failures++;
				if (failures <= REPORT_LIMIT)
					$display("unexpected result: status %0d pos %0d count %0d",
						got.status, got.found_position, got.entry_count);
				return;
			end
			p = awaiting.pop_front();
			checked++;
			if (got.status !== p.res.status || got.found_position !== p.res.found_position ||
					got.entry_count !== p.res.entry_count) begin
				failures++;
				if (failures <= REPORT_LIMIT)
					$display("mismatch op %0d: status %0d/%0d pos %0d/%0d count %0d/%0d (exp/got)",
						p.op, p.res.status, got.status, p.res.found_position,
						got.found_position, p.res.entry_count, got.entry_count);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [3:0] opcode = '0;
	logic [4:0] position = '0;
	logic signed [31:0] value = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [2:0] status;
	logic [3:0] found_position;
	logic [4:0] entry_count;

	list_scoreboard sb;
	idle_mode_t idle_mode = IDLE_FULL;
	logic [31:0] value_pool[4] = '{32'h0000_0007, 32'hffff_fff9, 32'h8000_0000, 32'h7fff_ffff};

	sequential_list_engine #(.CAPACITY(LIST_DEPTH)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.opcode(opcode),
		.position(position),
		.value(value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.found_position(found_position),
		.entry_count(entry_count)
	);

	always #5 clk = ~clk;

	function int draw_gap();
		case (idle_mode)
		IDLE_NONE: return 0;
		IDLE_FULL: return $urandom_range(0, MAX_WAIT);
		default: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, MAX_WAIT) : 0;
		endcase
	endfunction

	function logic [31:0] pick_value(int sz);
		int r;
		r = $urandom_range(0, 9);
		if (r < 5) return value_pool[$urandom_range(0, 3)];
		if (r < 7 && sz > 0) return sb.contents[$urandom_range(0, sz - 1)];
		return $urandom;
	endfunction

	task send_request(input logic [3:0] op, input logic [4:0] pos, input logic [31:0] v);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		position <= pos;
		value <= v;
		do @(posedge clk); while (in_stall !== 1'b0);
		sb.note_request(op, pos, v);
	endtask

	// hold off new transactions until every pending result is back
	task drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (sb.outstanding() != 0);
	endtask

	task run_directed();
		send_request(sle_pkg::OP_POP_FRONT, 5'd0, 32'd0);
		send_request(sle_pkg::OP_POP_BACK, 5'd0, 32'd0);
		send_request(sle_pkg::OP_ERASE, 5'd0, 32'd0);
		send_request(sle_pkg::OP_FIND, 5'd0, 32'd5);
		send_request(sle_pkg::OP_REMOVE_FIRST, 5'd0, 32'd5);
		send_request(sle_pkg::OP_REMOVE_ALL, 5'd0, 32'd5);
		send_request(sle_pkg::OP_INSERT, 5'd1, 32'd9);
		send_request(sle_pkg::OP_INSERT, 5'd0, 32'h8000_0000);
		send_request(sle_pkg::OP_PUSH_BACK, 5'd31, 32'h7fff_ffff);
		send_request(sle_pkg::OP_PUSH_FRONT, 5'd31, 32'hffff_ffff);
		send_request(sle_pkg::OP_INSERT, 5'd3, 32'h0000_0000);
		send_request(sle_pkg::OP_PUSH_BACK, 5'd0, 32'hffff_ffff);
		send_request(sle_pkg::OP_FIND, 5'd0, 32'hffff_ffff);
		send_request(sle_pkg::OP_FIND, 5'd0, 32'h7fff_ffff);
		send_request(sle_pkg::OP_REMOVE_ALL, 5'd0, 32'hffff_ffff);
		send_request(sle_pkg::OP_REMOVE_ALL, 5'd0, 32'h1234_5678);
		send_request(sle_pkg::OP_REMOVE_FIRST, 5'd0, 32'h7fff_ffff);
		send_request(sle_pkg::OP_ERASE, 5'd2, 32'd0);
		send_request(sle_pkg::OP_ERASE, 5'd31, 32'd0);
		send_request(sle_pkg::OP_REMOVE_ALL + 4'd1, 5'd0, 32'd0);
		send_request(OP_CODE_MAX, 5'd31, 32'hffff_ffff);
		send_request(sle_pkg::OP_INSERT, 5'd1, 32'h5555_aaaa);
		send_request(sle_pkg::OP_POP_BACK, 5'd0, 32'd0);
		send_request(sle_pkg::OP_POP_FRONT, 5'd0, 32'd0);
	endtask

	task run_random();
		int done;
		int issued;
		int r;
		int grow_pct;
		int sz;
		logic [3:0] op;
		logic [4:0] pos;
		logic [31:0] v;
		done = 0;
		issued = 0;
		grow_pct = 75;
		while (done < RANDOM_REQUESTS) begin
			// switch at random between filling and emptying phases so full and empty lists both occur
			if (issued % 32 == 0 && issued > 0) grow_pct = ($urandom_range(0, 1) == 1) ? 75 : 25;
			if (issued % 96 == 0) idle_mode = idle_mode_t'($urandom_range(0, 2));
			if (issued > 0 && issued % 200 == 0) drain();
			sz = sb.contents.size();
			r = $urandom_range(0, 99);
			if (r < grow_pct)
				op = 4'($urandom_range(sle_pkg::OP_PUSH_FRONT, sle_pkg::OP_INSERT));
			else if (r < 97)
				op = 4'($urandom_range(sle_pkg::OP_POP_FRONT, sle_pkg::OP_REMOVE_ALL));
			else
				op = 4'($urandom_range(sle_pkg::OP_REMOVE_ALL + 1, OP_CODE_MAX));
			if ($urandom_range(0, 9) < 8) begin
				if (op == sle_pkg::OP_ERASE && sz > 0) pos = 5'($urandom_range(0, sz - 1));
				else pos = 5'($urandom_range(0, sz));
			end else begin
				pos = 5'($urandom);
			end
			v = pick_value(sz);
			send_request(op, pos, v);
			issued++;
			if (op <= sle_pkg::OP_REMOVE_ALL) done++;
		end
	endtask

	initial begin : result_sink
		int gap;
		sle_pkg::res_t got;
		forever begin
			gap = draw_gap();
			if (gap > 0) begin
				out_stall <= 1'b1;
				repeat (gap) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (out_valid !== 1'b1);
			got.status = status;
			got.found_position = found_position;
			got.entry_count = entry_count;
			sb.check_result(got);
		end
	end

	initial begin
		#5ms;
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		sb = new(LIST_DEPTH);
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		drain();
		run_random();
		drain();
		repeat (2 * LIST_DEPTH + 8) @(posedge clk);
		$display("Ran %0d list transactions: %0d ok, %0d bad index, %0d full, %0d empty,",
			sb.checked, sb.status_hits[sle_pkg::ST_OK], sb.status_hits[sle_pkg::ST_BAD_INDEX],
			sb.status_hits[sle_pkg::ST_FULL], sb.status_hits[sle_pkg::ST_EMPTY]);
		$display("%0d not found; longest list held: %0d of %0d entries; %0d result errors.",
			sb.status_hits[sle_pkg::ST_NOT_FOUND], sb.peak, LIST_DEPTH, sb.failures);
		if (sb.failures == 0 && sb.outstanding() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

`default_nettype wire
